@@ rtl/core/swms_pkg.sv @@
package swms_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF   = 8;

  localparam int LEN_W   = 7;
  localparam int COUNT_W = 7;
  localparam int SUM_W   = 48;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd3;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;      // latch input word, start window read of the leaving value
    logic old_rd;      // window data valid: read count of the leaving value
    logic old_wr;      // write back decremented count
    logic new_rd;      // store value in window, read its count
    logic new_wr;      // write back incremented count, update fill
    logic scan_rd;     // issue one count read of the mode scan
    logic add_sum;     // add mode into running sum
    logic load_out;    // move result into output register
    logic clr_stream;  // drop fill and sum, rewind sweep counter
    logic clr_wr;      // write zero to one count entry
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic fill_ge_len;  // window already full before this word
    logic full;         // window full after this word
    logic cnt_end;      // sweep counter at last count entry
    logic out_free;     // output register can take a result
    logic last;         // current word ends the stream
  } stat_t;

endpackage

@@ rtl/core/sliding_window_mode_sum_unit.sv @@
// Channel  Direction  Handshake                      Payload
// cfg      in         cfg_valid_i / cfg_ready_o      cfg_data_i = window_length
// s_axis   in         s_axis_tvalid_i / tready_o     tdata = value, tlast = last
// m_axis   out        m_axis_tvalid_o / tready_i     tdata = full, mode, sum; tlast
//
// One word at a time. A word whose window is full runs a mode scan that reads one count per
// cycle over every count entry; a word on a partial window skips the scan. After reset,
// and after each word with tlast set, a clearing sweep zeroes every entry of the count
// RAM with s_axis_tready_o low; configuration writes are still taken. The result sits
// in an output register, so an m_axis stall holds only the word that needs it.
module sliding_window_mode_sum_unit #(
  parameter  int WindowDepth = swms_pkg::WINDOW_DEPTH_DEF,
  parameter  int ValueBits   = swms_pkg::VALUE_BITS_DEF,
  localparam int InW  = ((ValueBits + 7) / 8) * 8,
  localparam int OutW = ((1 + ValueBits + swms_pkg::SUM_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // window_length register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [swms_pkg::LEN_W-1:0] cfg_data_i,
  // input stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [InW-1:0]             s_axis_tdata_i,   // value
  input  logic                       s_axis_tlast_i,
  // result stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [OutW-1:0]            m_axis_tdata_o,   // window_full, mode, mode_sum
  output logic                       m_axis_tlast_o
);

  swms_pkg::cmd_t  cmd;
  swms_pkg::stat_t stat;

  logic                       out_full;
  logic [ValueBits-1:0]       out_mode;
  logic [swms_pkg::SUM_W-1:0] out_sum;

  // The register takes every write, so the port never stalls
  assign cfg_ready_o = 1'b1;

  swms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swms_dp #(
    .WindowDepth (WindowDepth),
    .ValueBits   (ValueBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_value_i  (s_axis_tdata_i[ValueBits-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_full_o  (out_full),
    .out_mode_o  (out_mode),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack result fields from bit 0 up, zero-fill to whole bytes
  assign m_axis_tdata_o = OutW'({out_sum, out_mode, out_full});

`ifndef SYNTHESIS
  // A result may only enter the output register when the slot is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending word");

  // A word is worked on alone: no second accept right after the first
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a word is in flight");

  // The mode reads as zero whenever the window is not full
  a_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_full) |-> (out_mode == '0))
    else $error("nonzero mode on a partial window");
`endif

endmodule

@@ rtl/core/swms_ram.sv @@
module swms_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/swms_ctrl.sv @@
module swms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swms_pkg::stat_t stat_i,
  output swms_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OLD_RD,
    ST_OLD_WR,
    ST_NEW_RD,
    ST_NEW_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_SUM,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.fill_ge_len ? ST_OLD_RD : ST_NEW_RD;
        end
      end
      ST_OLD_RD: begin
        cmd_o.old_rd = 1'b1;
        state_d = ST_OLD_WR;
      end
      ST_OLD_WR: begin
        cmd_o.old_wr = 1'b1;
        state_d = ST_NEW_RD;
      end
      ST_NEW_RD: begin
        cmd_o.new_rd = 1'b1;
        state_d = ST_NEW_WR;
      end
      ST_NEW_WR: begin
        cmd_o.new_wr = 1'b1;
        state_d = stat_i.full ? ST_SCAN : ST_OUT;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.cnt_end) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.add_sum = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (stat_i.last) begin
            cmd_o.clr_stream = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/swms_dp.sv @@
module swms_dp #(
  parameter int WindowDepth = swms_pkg::WINDOW_DEPTH_DEF,
  parameter int ValueBits   = swms_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swms_pkg::cmd_t                cmd_i,
  output swms_pkg::stat_t               stat_o,
  input  logic                          cfg_valid_i,
  input  logic [swms_pkg::LEN_W-1:0]    cfg_data_i,
  input  logic [ValueBits-1:0]          in_value_i,
  input  logic                          in_last_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_full_o,
  output logic [ValueBits-1:0]          out_mode_o,
  output logic [swms_pkg::SUM_W-1:0]    out_sum_o,
  output logic                          out_last_o
);

  localparam int LenW   = swms_pkg::LEN_W;
  localparam int CountW = swms_pkg::COUNT_W;
  localparam int SumW   = swms_pkg::SUM_W;
  localparam int AddrW  = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int NumValues = 1 << ValueBits;
  localparam int LenCapI   = (WindowDepth < 127) ? WindowDepth : 127;

  localparam logic [LenW-1:0]  LenCap    = LenW'(LenCapI);
  localparam logic [AddrW-1:0] WinLast   = AddrW'(WindowDepth - 1);
  localparam logic [AddrW:0]   WinDepthX = (AddrW + 1)'(WindowDepth);

  logic [LenW-1:0]      cfg_q;
  logic [LenW-1:0]      len;
  logic [ValueBits-1:0] v_q;
  logic                 last_q;
  logic [AddrW-1:0]     wp_q;
  logic [LenW-1:0]      fill_q;
  logic [LenW-1:0]      fill_inc;
  logic                 full_q;
  logic [ValueBits-1:0] old_q;
  logic [ValueBits-1:0] cnt_q;
  logic [ValueBits-1:0] addr_d1_q;
  logic                 scan_vld_q;
  logic [ValueBits-1:0] best_q;
  logic [CountW-1:0]    best_cnt_q;
  logic [SumW-1:0]      sum_q;
  logic [SumW:0]        sum_add;

  logic                 out_vld_q;
  logic                 out_full_q;
  logic [ValueBits-1:0] out_mode_q;
  logic [SumW-1:0]      out_sum_q;
  logic                 out_last_q;

  logic [AddrW:0]       wp_x;
  logic [AddrW:0]       len_x;
  logic [AddrW-1:0]     old_idx;
  logic [ValueBits-1:0] win_rdata;

  logic                 cnt_we;
  logic [ValueBits-1:0] cnt_waddr;
  logic [ValueBits-1:0] cnt_raddr;
  logic [CountW-1:0]    cnt_wdata;
  logic [CountW-1:0]    cnt_rdata;

  // Clamp the configured length into the legal window range
  always_comb begin
    len = cfg_q;
    if (len == '0) begin
      len = LenW'(1);
    end
    if (len > LenCap) begin
      len = LenCap;
    end
  end

  // Ring slot of the value leaving the window
  assign wp_x  = {1'b0, wp_q};
  assign len_x = (AddrW + 1)'(len);
  always_comb begin
    if (wp_x >= len_x) begin
      old_idx = AddrW'(wp_x - len_x);
    end else begin
      old_idx = AddrW'(wp_x + WinDepthX - len_x);
    end
  end

  assign fill_inc = (fill_q < len) ? fill_q + LenW'(1) : fill_q;

  swms_ram #(
    .Width (ValueBits),
    .Depth (WindowDepth)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.new_rd),
    .waddr_i (wp_q),
    .wdata_i (v_q),
    .raddr_i (old_idx),
    .rdata_o (win_rdata)
  );

  always_comb begin
    if (cmd_i.old_rd) begin
      cnt_raddr = win_rdata;
    end else if (cmd_i.new_rd) begin
      cnt_raddr = v_q;
    end else begin
      cnt_raddr = cnt_q;
    end
  end

  // Saturating count update, or zero during the clearing sweep
  always_comb begin
    cnt_we    = cmd_i.old_wr | cmd_i.new_wr | cmd_i.clr_wr;
    cnt_waddr = cnt_q;
    cnt_wdata = '0;
    if (cmd_i.old_wr) begin
      cnt_waddr = old_q;
      cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CountW'(1) : cnt_rdata;
    end else if (cmd_i.new_wr) begin
      cnt_waddr = v_q;
      cnt_wdata = (cnt_rdata != '1) ? cnt_rdata + CountW'(1) : cnt_rdata;
    end
  end

  swms_ram #(
    .Width (CountW),
    .Depth (NumValues)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign sum_add = {1'b0, sum_q} + (SumW + 1)'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= swms_pkg::LEN_RESET;
      wp_q       <= '0;
      fill_q     <= '0;
      cnt_q      <= '0;
      scan_vld_q <= 1'b0;
      sum_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.new_rd) begin
        wp_q <= (wp_q == WinLast) ? '0 : wp_q + AddrW'(1);
      end
      if (cmd_i.new_wr) begin
        fill_q <= fill_inc;
      end
      if (cmd_i.accept || cmd_i.clr_stream) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.clr_wr) begin
        cnt_q <= cnt_q + ValueBits'(1);
      end
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.add_sum) begin
        sum_q <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
      end
      if (cmd_i.clr_stream) begin
        fill_q <= '0;
        sum_q  <= '0;
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q        <= in_value_i;
      last_q     <= in_last_i;
      best_q     <= '0;
      best_cnt_q <= '0;
    end else if (scan_vld_q && (cnt_rdata > best_cnt_q)) begin
      best_q     <= addr_d1_q;
      best_cnt_q <= cnt_rdata;
    end
    addr_d1_q <= cnt_q;
    if (cmd_i.old_rd) begin
      old_q <= win_rdata;
    end
    if (cmd_i.new_wr) begin
      full_q <= (fill_inc >= len);
    end
    if (cmd_i.load_out) begin
      out_full_q <= full_q;
      out_mode_q <= best_q;
      out_sum_q  <= sum_q;
      out_last_q <= last_q;
    end
  end

  assign stat_o.fill_ge_len = (fill_q >= len);
  assign stat_o.full        = (fill_inc >= len);
  assign stat_o.cnt_end     = (cnt_q == '1);
  assign stat_o.out_free    = !out_vld_q || out_ready_i;
  assign stat_o.last        = last_q;

  assign out_valid_o = out_vld_q;
  assign out_full_o  = out_full_q;
  assign out_mode_o  = out_mode_q;
  assign out_sum_o   = out_sum_q;
  assign out_last_o  = out_last_q;

endmodule

@@ bench/tb_top.sv @@
module tb_top;

  localparam int DataInW      = 8;
  localparam int DataOutW     = 64;
  localparam int RingDepth    = 64;
  localparam int NumValues    = 256;
  localparam int CountMax     = 127;
  localparam int TargetWords  = 1300;
  localparam int LongHold     = 3000;
  localparam int DrainCycles  = 300;
  localparam int MaxShown     = 40;
  localparam longint CycleLimit = 4_000_000;

  // Value styles for a stream
  localparam int StyleFull    = 0;
  localparam int StylePool    = 1;
  localparam int StyleEdges   = 2;

  typedef struct packed {
    bit                       full;
    bit [7:0]                 mode;
    bit [swms_pkg::SUM_W-1:0] sum;
    bit                       last;
  } mode_result_t;

  // Tracks window contents and per-value tallies; queues the result each word should give.
  class mode_sum_board;
    bit [swms_pkg::LEN_W-1:0]   length_reg;
    bit [7:0]                   ring [RingDepth];
    bit [swms_pkg::COUNT_W-1:0] tally [NumValues];
    int unsigned                wr_ptr;
    int unsigned                fill;
    bit [swms_pkg::SUM_W-1:0]   total;
    mode_result_t               pending_results [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                words;

    function new();
      length_reg = swms_pkg::LEN_RESET;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (tally[i]) tally[i] = '0;
      fill  = 0;
      total = '0;
    endfunction

    function void take_word(bit [7:0] v, bit last);
      int unsigned            span;
      int unsigned            idx;
      int unsigned            best_count;
      int                     i;
      bit [7:0]               best;
      bit [swms_pkg::SUM_W:0] wide;
      mode_result_t           r;
      span = length_reg;
      if (span == 0) span = 1;
      if (span > RingDepth) span = RingDepth;
      // drop the value that leaves a full window
      if (fill >= span) begin
        idx = (wr_ptr + RingDepth - span) % RingDepth;
        if (tally[ring[idx]] != 0) tally[ring[idx]]--;
      end
      ring[wr_ptr] = v;
      wr_ptr = (wr_ptr + 1) % RingDepth;
      if (tally[v] < CountMax) tally[v]++;
      if (fill < span) fill++;
      r = '0;
      r.last = last;
      if (fill >= span) begin
        best = '0;
        best_count = 0;
        for (i = 0; i < NumValues; i++) begin
          if (tally[i] > best_count) begin
            best_count = tally[i];
            best = i[7:0];
          end
        end
        wide  = total + best;
        total = wide[swms_pkg::SUM_W] ? '1 : wide[swms_pkg::SUM_W-1:0];
        r.full = 1'b1;
        r.mode = best;
      end
      r.sum = total;
      pending_results.push_back(r);
      words++;
      if (last) clear_stream();
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= MaxShown)
        $display("%0t ERROR %s: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(bit [DataOutW-1:0] data, bit last);
      mode_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("%0t ERROR result word with nothing expected: expected none, actual 0x%h",
                   $time, data);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (data[0] != want.full)          report("window_full", want.full, data[0]);
      if (data[8:1] != want.mode)        report("mode", want.mode, data[8:1]);
      if (data[56:9] != want.sum)        report("mode_sum", want.sum, data[56:9]);
      if (last != want.last)             report("last", want.last, last);
      if (data[DataOutW-1:57] != '0)     report("tdata padding", 0, data[DataOutW-1:57]);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [swms_pkg::LEN_W-1:0] cfg_data_i = '0;
  logic                       s_axis_tvalid_i = 1'b0;
  logic                       s_axis_tready_o;
  logic [DataInW-1:0]         s_axis_tdata_i = '0;   // value
  logic                       s_axis_tlast_i = 1'b0;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i = 1'b0;
  logic [DataOutW-1:0]        m_axis_tdata_o;        // window_full, mode, mode_sum
  logic                       m_axis_tlast_o;

  mode_sum_board sb = new();

  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned results_taken = 0;
  int unsigned cfg_writes = 0;
  int unsigned streams_closed = 0;
  longint      cycle_count = 0;

  sliding_window_mode_sum_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles, %0d results still expected",
               $time, cycle_count, sb.pending_results.size());
      $display("** sliding_window_mode_sum_unit: FAILED **");
      $finish;
    end
  end

  // Observe all three handshakes at the rising edge; check the older result first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.length_reg = cfg_data_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
        results_taken++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) sb.take_word(s_axis_tdata_i, s_axis_tlast_i);
    end
  end

  // Mostly no gap, often a short one, seldom a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  // Result sink: stall each result word for a random time, or hold off for a long stretch
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned armed_for;
    stall_left = 0;
    hold_left  = 0;
    armed_for  = 32'hFFFF_FFFF;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (m_axis_tvalid_o && armed_for != results_taken) begin
        armed_for  = results_taken;
        stall_left = rx_steady ? 0 : pick_gap();
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = m_axis_tvalid_o || rx_steady || ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offer one word after an optional gap; return at the falling edge after it is taken
  task automatic send_word(input logic [7:0] v, input logic last);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = v;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    if (last) streams_closed++;
  endtask

  // Stop offering words and wait for every expected result
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_window_length(input logic [swms_pkg::LEN_W-1:0] len);
    cfg_valid_i = 1'b1;
    cfg_data_i  = len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  // Send n words; a small value pool gives repeats and ties, the others spread the bits
  task automatic send_stream(input int unsigned n, input bit close, input int unsigned style);
    logic [7:0]  pool [6];
    logic [7:0]  v;
    int unsigned pool_size;
    int unsigned k;
    pool_size = $urandom_range(2, 6);
    foreach (pool[i]) pool[i] = $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      case (style)
        StyleFull: begin
          v = $urandom_range(0, 255);
        end
        StylePool: begin
          v = pool[$urandom_range(0, pool_size - 1)];
        end
        default: begin
          case ($urandom_range(0, 3))
            0: v = 8'd0;
            1: v = 8'd1;
            2: v = 8'd128;
            default: v = 8'd255;
          endcase
        end
      endcase
      send_word(v, close && (k == n - 1));
    end
  endtask

  initial begin : stimulus
    logic [swms_pkg::LEN_W-1:0] edge_lengths [7];
    logic [swms_pkg::LEN_W-1:0] len;
    int unsigned                span;
    int unsigned                phase;
    int unsigned                n_streams;
    int unsigned                s;
    int unsigned                n;
    int unsigned                style;
    int unsigned                r;
    bit                         close;

    edge_lengths = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd2, 7'd33};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset length of three, extremes, a zero value, a three-way tie
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd1,   1'b0);
    send_word(8'd1,   1'b0);
    send_word(8'd0,   1'b0);
    send_word(8'd0,   1'b0);
    send_word(8'd200, 1'b0);
    send_word(8'd5,   1'b0);
    send_word(8'd7,   1'b1);
    wait_drained();
    write_window_length(7'd1);
    send_word(8'd17,  1'b0);
    send_word(8'd0,   1'b0);
    send_word(8'd255, 1'b1);
    wait_drained();
    // zero acts as one
    write_window_length(7'd0);
    send_word(8'd42,  1'b0);
    send_word(8'd42,  1'b1);
    wait_drained();
    // above depth: window never fills in three words, then shrink it mid-stream
    write_window_length(7'd127);
    send_word(8'd3,   1'b0);
    send_word(8'd9,   1'b0);
    send_word(8'd200, 1'b0);
    wait_drained();
    write_window_length(7'd2);
    send_word(8'd9,   1'b0);
    send_word(8'd9,   1'b1);

    // Random phases: a new length while idle, then one to three streams
    phase = 0;
    while (sb.words < TargetWords) begin
      wait_drained();
      if (phase < $size(edge_lengths)) begin
        len = edge_lengths[phase];
      end else if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(0, 127);
      end else begin
        len = $urandom_range(1, 64);
      end
      write_window_length(len);
      span = (len == 0) ? 1 : ((len > RingDepth) ? RingDepth : len);
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      // fill the block up against a long result stall once
      if (phase == 2) begin
        rx_steady    = 1'b0;
        hold_request = 1'b1;
      end
      n_streams = $urandom_range(1, 3);
      for (s = 0; s < n_streams; s++) begin
        r = $urandom_range(0, 9);
        n = (r == 0) ? $urandom_range(1, span) : span + $urandom_range(0, span + 8);
        r = $urandom_range(0, 9);
        style = (r < 6) ? StylePool : ((r < 9) ? StyleFull : StyleEdges);
        // leave the final stream open now and then so the next length lands mid-stream
        close = !(s == n_streams - 1 && $urandom_range(0, 5) == 0);
        send_stream(n, close, style);
      end
      phase++;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d words in %0d closed streams, %0d length writes, %0d results checked.",
             sb.words, streams_closed, cfg_writes, sb.checked);
    $display("Lengths 0, 1, 64, 65 and 127 used, plus a %0d-cycle hold on the result side.",
             LongHold);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("** sliding_window_mode_sum_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               sb.errors, sb.pending_results.size());
      $display("** sliding_window_mode_sum_unit: FAILED **");
    end
    $finish;
  end

endmodule
